### sv/phit_pkg.sv
// Shared types and constants for the polygon hit test block.
// Coordinate, vertex and product types, command codes.
// No dependencies.
package phit_pkg;

  localparam int TAG_W  = 16;
  localparam int DIFF_W = 17;
  localparam int PROD_W = 2 * DIFF_W;

  typedef logic signed [15:0] coord_t;

  // x in the low half, y in the high half
  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

endpackage

### sv/phit_edge_mul.sv
// Shared signed multiplier for the edge crossing test.
// Selects one of the two cross products of an edge and registers it.
// Depends on phit_pkg.
module phit_edge_mul (
  input  logic             clk,
  input  logic             rhs_sel,
  input  phit_pkg::vertex_t q,
  input  phit_pkg::vertex_t a,
  input  phit_pkg::vertex_t b,
  output phit_pkg::prod_t   prod
);

  phit_pkg::diff_t op0;
  phit_pkg::diff_t op1;

  // lhs = (qx - ax) * (by - ay), rhs = (bx - ax) * (qy - ay)
  always_comb begin
    if (rhs_sel) begin
      op0 = $signed({b.x[15], b.x}) - $signed({a.x[15], a.x});
      op1 = $signed({q.y[15], q.y}) - $signed({a.y[15], a.y});
    end else begin
      op0 = $signed({q.x[15], q.x}) - $signed({a.x[15], a.x});
      op1 = $signed({b.y[15], b.y}) - $signed({a.y[15], a.y});
    end
  end

  always_ff @(posedge clk) begin
    prod <= op0 * op1;
  end

endmodule

### sv/polygon_hit_test.sv
// Top level of the polygon hit test block: region and vertex stores, query sequencer.
// Uses phit_pkg and phit_edge_mul.
//
// Clear and add-vertex requests complete in the idle state as they are
// taken. A query walks the region table in order and tests every edge of
// each region against the point with the crossing-number rule, using one
// 17x17 multiplier twice per edge. A region with fewer than three vertices
// is not tested, and the walk stops at the first hit. The edge walk is
// paced by the multiplier and by the single read port of the vertex store.
// The input is not ready while a query runs; a finished result waits in an
// output register, and the next request is taken meanwhile.
module polygon_hit_test #(
  parameter int MAX_REGIONS  = 64,
  parameter int MAX_VERTICES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // region_tag[15:0], px[31:16], py[47:32]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  input  logic        s_axis_tlast,   // closes_region
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // found[0], found_tag[16:1], overflowed[17], zero pad
);

  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int RCW = $clog2(MAX_REGIONS + 1);
  localparam int RAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RTW = phit_pkg::TAG_W + 2 * VCW;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_REG_RD  = 4'd1;
  localparam logic [3:0] ST_REG_CHK = 4'd2;
  localparam logic [3:0] ST_LD_B    = 4'd3;
  localparam logic [3:0] ST_LD_A    = 4'd4;
  localparam logic [3:0] ST_EDGE_L  = 4'd5;
  localparam logic [3:0] ST_EDGE_R  = 4'd6;
  localparam logic [3:0] ST_FIN     = 4'd7;
  localparam logic [3:0] ST_OUT     = 4'd8;

  // stores
  phit_pkg::vertex_t vmem [MAX_VERTICES];
  logic [RTW-1:0]    rmem [MAX_REGIONS];
  phit_pkg::vertex_t vq;
  logic [RTW-1:0]    rq;
  logic [VAW-1:0]    vaddr;

  // control
  logic [3:0]     state;
  logic [RCW-1:0] region_count;
  logic [VCW-1:0] vertex_count;
  logic [VCW-1:0] open_start;
  logic           overflow;
  logic [RCW-1:0] r;
  logic [VCW-1:0] k;
  logic           parity;
  logic           pend;
  logic           dpos;
  logic           hit;

  // payload
  phit_pkg::vertex_t q;
  phit_pkg::vertex_t a;
  phit_pkg::vertex_t b;
  phit_pkg::prod_t   prod;
  phit_pkg::prod_t   lhs;
  logic [phit_pkg::TAG_W-1:0] hit_tag;
  logic [phit_pkg::TAG_W-1:0] reg_tag;
  logic [VCW-1:0]    reg_start;
  logic [VCW-1:0]    reg_len;

  // request fields
  logic                       req;
  logic [1:0]                 cmd;
  logic [phit_pkg::TAG_W-1:0] in_tag;
  phit_pkg::vertex_t          in_v;
  logic                       vfull;
  logic                       rfull;
  logic [VCW-1:0]             vc_next;
  logic                       vwe;
  logic                       rwe;

  // region entry fields
  logic [VCW-1:0]             rq_len;
  logic [VCW-1:0]             rq_start;
  logic [phit_pkg::TAG_W-1:0] rq_tag;

  logic [VCW-1:0] next_a_idx;
  logic [VCW-1:0] last_idx;
  logic           last_region;
  logic           last_edge;
  logic           crosses;
  logic           cond;
  logic           parity_next;
  logic           rhs_sel;
  logic           out_load;

  assign s_axis_tready = (state == ST_IDLE);
  assign req    = s_axis_tvalid && s_axis_tready;
  assign cmd    = s_axis_tuser;
  assign in_tag = s_axis_tdata[15:0];
  assign in_v   = s_axis_tdata[47:16];

  assign vfull   = (vertex_count == VCW'(MAX_VERTICES));
  assign rfull   = (region_count == RCW'(MAX_REGIONS));
  assign vc_next = vfull ? vertex_count : VCW'(vertex_count + 1'b1);
  assign vwe     = req && (cmd == phit_pkg::CMD_ADD) && !vfull;
  assign rwe     = req && (cmd == phit_pkg::CMD_ADD) && s_axis_tlast && !rfull;

  assign rq_len   = rq[VCW-1:0];
  assign rq_start = rq[2*VCW-1:VCW];
  assign rq_tag   = rq[RTW-1:2*VCW];

  assign next_a_idx  = VCW'(reg_start + k + 1'b1);
  assign last_idx    = VCW'(rq_start + rq_len - 1'b1);
  assign last_region = (RCW'(r + 1'b1) == region_count);
  assign last_edge   = (k == VCW'(reg_len - 1'b1));

  // strict comparisons as in the crossing rule
  assign cond    = ($signed(a.y) > $signed(q.y)) != ($signed(b.y) > $signed(q.y));
  assign crosses = dpos ? (lhs < prod) : (lhs > prod);
  assign parity_next = parity ^ (pend && crosses);
  assign rhs_sel = (state == ST_EDGE_R);
  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    case (state)
      ST_REG_CHK: vaddr = last_idx[VAW-1:0];
      ST_LD_B:    vaddr = reg_start[VAW-1:0];
      default:    vaddr = next_a_idx[VAW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vertex_count[VAW-1:0]] <= in_v;
    end
    vq <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (rwe) begin
      rmem[region_count[RAW-1:0]] <= {in_tag, open_start, VCW'(vc_next - open_start)};
    end
    rq <= rmem[r[RAW-1:0]];
  end

  phit_edge_mul u_mul (
    .clk     (clk),
    .rhs_sel (rhs_sel),
    .q       (q),
    .a       (a),
    .b       (b),
    .prod    (prod)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      region_count  <= '0;
      vertex_count  <= '0;
      open_start    <= '0;
      overflow      <= 1'b0;
      r             <= '0;
      k             <= '0;
      parity        <= 1'b0;
      pend          <= 1'b0;
      dpos          <= 1'b0;
      hit           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req) begin
            case (cmd)
              phit_pkg::CMD_CLEAR: begin
                region_count <= '0;
                vertex_count <= '0;
                open_start   <= '0;
                overflow     <= 1'b0;
              end
              phit_pkg::CMD_ADD: begin
                vertex_count <= vc_next;
                if (vfull || (s_axis_tlast && rfull)) begin
                  overflow <= 1'b1;
                end
                if (s_axis_tlast) begin
                  open_start <= vc_next;
                  if (!rfull) begin
                    region_count <= RCW'(region_count + 1'b1);
                  end
                end
              end
              phit_pkg::CMD_QUERY: begin
                hit <= 1'b0;
                r   <= '0;
                state <= (region_count == '0) ? ST_OUT : ST_REG_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_REG_RD: state <= ST_REG_CHK;
        ST_REG_CHK: begin
          if (rq_len < VCW'(3)) begin
            if (last_region) begin
              state <= ST_OUT;
            end else begin
              r     <= RCW'(r + 1'b1);
              state <= ST_REG_RD;
            end
          end else begin
            k      <= '0;
            parity <= 1'b0;
            pend   <= 1'b0;
            state  <= ST_LD_B;
          end
        end
        ST_LD_B: state <= ST_LD_A;
        ST_LD_A: state <= ST_EDGE_L;
        ST_EDGE_L: begin
          parity <= parity_next;
          state  <= ST_EDGE_R;
        end
        ST_EDGE_R: begin
          // lhs product is in prod now; rhs lands next cycle
          pend <= cond;
          dpos <= $signed(b.y) > $signed(a.y);
          k    <= VCW'(k + 1'b1);
          state <= last_edge ? ST_FIN : ST_EDGE_L;
        end
        ST_FIN: begin
          pend <= 1'b0;
          if (parity_next) begin
            hit   <= 1'b1;
            state <= ST_OUT;
          end else if (last_region) begin
            state <= ST_OUT;
          end else begin
            r     <= RCW'(r + 1'b1);
            state <= ST_REG_RD;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (req && (cmd == phit_pkg::CMD_QUERY)) begin
      q       <= in_v;
      hit_tag <= '0;
    end
    if (state == ST_REG_CHK) begin
      reg_start <= rq_start;
      reg_len   <= rq_len;
      reg_tag   <= rq_tag;
    end
    if (state == ST_LD_B) begin
      b <= vq;
    end
    if (state == ST_LD_A) begin
      a <= vq;
    end
    if (state == ST_EDGE_R) begin
      lhs <= prod;
      b   <= a;
      a   <= vq;
    end
    if ((state == ST_FIN) && parity_next) begin
      hit_tag <= reg_tag;
    end
    if (out_load) begin
      m_axis_tdata <= {6'b0, overflow, hit_tag, hit};
    end
  end

endmodule

### bench/hit_test_checker.sv
// Checker for polygon_hit_test: watches both stream channels, keeps its own copy of the
// region and vertex tables, predicts each query answer and compares it with the block.
// Depends on phit_pkg.
`timescale 1ns / 1ps

module hit_test_checker #(
  parameter int MAX_REGIONS  = 64,
  parameter int MAX_VERTICES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // region_tag[15:0], px[31:16], py[47:32]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  input  logic        s_axis_tlast,   // closes_region
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // found[0], found_tag[16:1], overflowed[17], zero pad
  output int          errors,
  output int          outstanding
);

  typedef struct {
    logic [15:0] tag;
    int unsigned first;
    int unsigned count;
  } region_rec_t;

  typedef struct {
    logic        found;
    logic [15:0] tag;
    logic        ovf;
  } hit_answer_t;

  phit_pkg::vertex_t vstore [MAX_VERTICES];
  region_rec_t       regions[MAX_REGIONS];
  int unsigned       n_regions;
  int unsigned       n_vertices;
  int unsigned       open_start;
  logic              overflow;
  hit_answer_t       pending_answers[$];

  // Even-odd crossing rule, cross-multiplied so the sign of the edge's dy picks the
  // direction of the comparison.
  function automatic logic point_in_region(region_rec_t rg, phit_pkg::coord_t qx,
                                           phit_pkg::coord_t qy);
    logic              parity;
    int unsigned       k;
    int unsigned       prev;
    phit_pkg::vertex_t a;
    phit_pkg::vertex_t b;
    longint            d;
    longint            lhs;
    longint            rhs;
    parity = 1'b0;
    prev   = rg.count - 1;
    for (k = 0; k < rg.count; k++) begin
      a = vstore[rg.first + k];
      b = vstore[rg.first + prev];
      if ((a.y > qy) != (b.y > qy)) begin
        d   = longint'(b.y) - longint'(a.y);
        lhs = (longint'(qx) - longint'(a.x)) * d;
        rhs = (longint'(b.x) - longint'(a.x)) * (longint'(qy) - longint'(a.y));
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs))
          parity = !parity;
      end
      prev = k;
    end
    return parity;
  endfunction

  function automatic hit_answer_t predict_hit(phit_pkg::coord_t qx, phit_pkg::coord_t qy);
    hit_answer_t ans;
    int unsigned r;
    ans.found = 1'b0;
    ans.tag   = '0;
    ans.ovf   = overflow;
    for (r = 0; r < n_regions && !ans.found; r++) begin
      if (regions[r].count >= 3 && point_in_region(regions[r], qx, qy)) begin
        ans.found = 1'b1;
        ans.tag   = regions[r].tag;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    hit_answer_t      got;
    hit_answer_t      want;
    logic [15:0]      tag;
    phit_pkg::coord_t x;
    phit_pkg::coord_t y;
    if (rst) begin
      n_regions  = 0;
      n_vertices = 0;
      open_start = 0;
      overflow   = 1'b0;
      pending_answers.delete();
    end else begin
      // results first: a result can never belong to a request taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tdata[0];
        got.tag   = m_axis_tdata[16:1];
        got.ovf   = m_axis_tdata[17];
        if (pending_answers.size() == 0) begin
          $error("result with no query waiting: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
          end
          if (got.tag !== want.tag) begin
            $error("found_tag: expected %h, actual %h", want.tag, got.tag);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflowed: expected %0d, actual %0d", want.ovf, got.ovf);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tag = s_axis_tdata[15:0];
        x   = s_axis_tdata[31:16];
        y   = s_axis_tdata[47:32];
        case (s_axis_tuser)
          phit_pkg::CMD_CLEAR: begin
            n_regions  = 0;
            n_vertices = 0;
            open_start = 0;
            overflow   = 1'b0;
          end
          phit_pkg::CMD_ADD: begin
            if (n_vertices < MAX_VERTICES) begin
              vstore[n_vertices].x = x;
              vstore[n_vertices].y = y;
              n_vertices++;
            end else begin
              overflow = 1'b1;
            end
            if (s_axis_tlast) begin
              if (n_regions < MAX_REGIONS) begin
                regions[n_regions].tag   = tag;
                regions[n_regions].first = open_start;
                regions[n_regions].count = n_vertices - open_start;
                n_regions++;
              end else begin
                overflow = 1'b1;
              end
              open_start = n_vertices;
            end
          end
          phit_pkg::CMD_QUERY: begin
            want = predict_hit(x, y);
            pending_answers.insert(pending_answers.size(), want);
          end
          default: ;
        endcase
      end
    end
    outstanding = pending_answers.size();
  end

endmodule

### bench/testbench.sv
// Top of the polygon_hit_test bench: clock, reset, request and result stream drivers,
// verdict. Prediction and comparison live in hit_test_checker.
// Depends on phit_pkg, polygon_hit_test and hit_test_checker.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // region_tag[15:0], px[31:16], py[47:32]
  logic [1:0]  s_axis_tuser = '0;   // command[1:0]
  logic        s_axis_tlast = 1'b0; // closes_region
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // found[0], found_tag[16:1], overflowed[17], zero pad

  int errors;
  int outstanding;
  int n_requests;
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_hold;

  always #5 clk = ~clk;

  polygon_hit_test #(
    .MAX_REGIONS (64),
    .MAX_VERTICES(512)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  hit_test_checker #(
    .MAX_REGIONS (64),
    .MAX_VERTICES(512)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  function automatic phit_pkg::coord_t clamp16(int v);
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  function automatic phit_pkg::coord_t near(int c, int r);
    return clamp16(c - r + int'($urandom_range(0, 2 * r)));
  endfunction

  task automatic send_req(logic [1:0] cmd, logic [15:0] tag, phit_pkg::coord_t x,
                          phit_pkg::coord_t y, logic closes);
    while (tx_idle_on && $urandom_range(0, 99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x, tag};
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= closes;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd != CMD_UNUSED) n_requests++;
  endtask

  task automatic add_vertex(phit_pkg::coord_t x, phit_pkg::coord_t y, logic closes,
                            logic [15:0] tag);
    send_req(phit_pkg::CMD_ADD, tag, x, y, closes);
  endtask

  task automatic query_at(phit_pkg::coord_t x, phit_pkg::coord_t y);
    send_req(phit_pkg::CMD_QUERY, 16'($urandom), x, y, 1'($urandom_range(0, 1)));
  endtask

  task automatic clear_all();
    send_req(phit_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom_range(0, 1)));
  endtask

  // sender stops and waits for every outstanding answer
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic add_region(int cx, int cy, int rad, int len);
    int w;
    int h;
    int i;
    if (len == 4 && $urandom_range(0, 1)) begin
      w = $urandom_range(1, rad);
      h = $urandom_range(1, rad);
      add_vertex(clamp16(cx - w), clamp16(cy - h), 1'b0, 16'($urandom));
      add_vertex(clamp16(cx + w), clamp16(cy - h), 1'b0, 16'($urandom));
      add_vertex(clamp16(cx + w), clamp16(cy + h), 1'b0, 16'($urandom));
      add_vertex(clamp16(cx - w), clamp16(cy + h), 1'b1, 16'($urandom));
    end else begin
      for (i = 0; i < len; i++)
        add_vertex(near(cx, rad), near(cy, rad), i == len - 1, 16'($urandom));
    end
  endtask

  task automatic noise_request();
    case ($urandom_range(0, 2))
      0: send_req(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom_range(0, 1)));
      1: query_at(16'($urandom), 16'($urandom));
      default: add_vertex(16'($urandom), 16'($urandom), 1'b0, 16'($urandom));
    endcase
  endtask

  task automatic random_scene();
    int cx;
    int cy;
    int rad;
    int len;
    cx = int'($urandom_range(0, 60000)) - 30000;
    cy = int'($urandom_range(0, 60000)) - 30000;
    case ($urandom_range(0, 3))
      0: rad = $urandom_range(1, 8);   // tiny: points land on edges and vertices
      1, 2: rad = $urandom_range(16, 2000);
      default: rad = $urandom_range(2000, 2700);
    endcase
    if ($urandom_range(0, 9) < 8) clear_all();
    repeat ($urandom_range(1, 5)) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      add_region(cx, cy, rad, len);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 9) == 0) noise_request();
        query_at(near(cx, rad + rad / 2), near(cy, rad + rad / 2));
      end
    end
  endtask

  // push the vertex store past its capacity, and the region store when enough regions come, then clear
  task automatic fill_stores();
    int cx;
    int cy;
    int added;
    int regs;
    int len;
    cx = int'($urandom_range(0, 20000)) - 10000;
    cy = int'($urandom_range(0, 20000)) - 10000;
    added = 0;
    regs  = 0;
    clear_all();
    while (added < 530) begin
      len = $urandom_range(3, 12);
      add_region(cx, cy, 500, len);
      added += len;
      regs++;
      if (regs % 6 == 0) query_at(near(cx, 700), near(cy, 700));
    end
    repeat (4) query_at(near(cx, 600), near(cy, 600));
    query_at(-16'sd32768, 16'sd32767);
    clear_all();
    query_at(clamp16(cx), clamp16(cy));
  endtask

  task automatic directed_requests();
    query_at(16'sd0, 16'sd0);
    add_vertex(-16'sd32768, -16'sd32768, 1'b0, 16'h0000);
    add_vertex(16'sd32767, -16'sd32768, 1'b0, 16'h0000);
    add_vertex(16'sd0, 16'sd32767, 1'b1, 16'hFFFF);
    query_at(16'sd0, 16'sd0);
    query_at(-16'sd32768, -16'sd32768);
    query_at(16'sd32767, 16'sd32767);
    query_at(16'sd0, -16'sd32768);
    // two-vertex and one-vertex regions are recorded but never match
    add_vertex(16'sd100, 16'sd100, 1'b0, 16'h0000);
    add_vertex(16'sd200, 16'sd200, 1'b1, 16'h0001);
    add_vertex(16'sd5, 16'sd5, 1'b1, 16'h0002);
    send_req(CMD_UNUSED, 16'hFFFF, -16'sd1, -16'sd1, 1'b1);
    query_at(16'sd0, 16'sd0);
    clear_all();
    query_at(16'sd0, 16'sd0);
    add_vertex(16'sd0, 16'sd0, 1'b0, 16'h0000);
    add_vertex(16'sd16, 16'sd0, 1'b0, 16'h0000);
    add_vertex(16'sd16, 16'sd16, 1'b0, 16'h0000);
    add_vertex(16'sd0, 16'sd16, 1'b1, 16'hA5A5);
    query_at(16'sd0, 16'sd8);
    query_at(16'sd16, 16'sd8);
    query_at(16'sd8, 16'sd0);
    query_at(16'sd8, 16'sd16);
    query_at(16'sd8, 16'sd8);
    query_at(16'sd0, 16'sd0);
  endtask

  // result side: random stalls, or one long hold-off counted here
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 31);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int scene;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold    = 1'b0;
    n_requests = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_requests();
    drain_results();
    scene = 0;
    while (n_requests < 100) begin
      // a stretch with no idling on either side
      tx_idle_on = !(scene >= 2 && scene < 4);
      rx_idle_on = tx_idle_on;
      if (scene == 1) begin
        // result side holds off while queries keep coming, so the input backs up
        rx_hold = 1'b1;
        add_region(0, 0, 1000, 5);
        repeat (10) query_at(near(0, 1200), near(0, 1200));
        drain_results();
      end
      random_scene();
      if (scene % 2 == 1) drain_results();
      scene++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    drain_results();
    fill_stores();
    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### polygon_hit_test.f
sv/phit_pkg.sv
sv/phit_edge_mul.sv
sv/polygon_hit_test.sv
bench/hit_test_checker.sv
bench/testbench.sv
